[rtl/bncf_pkg.sv]
// Shared types and constants for the binary neighbor count filter.
// Register indexes, field widths, reset values and the neighbor mask type.
// No dependencies.
`timescale 1ns / 1ps

package bncf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGHBORS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MARGIN   = 3'd4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [7:0]            RST_THRESHOLD    = 8'd127;
  localparam logic [3:0]            RST_MIN_NB       = 4'd4;
  localparam logic [3:0]            RST_MARGIN       = 4'd5;

  // Request field codes and widths
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int   PIX_W    = 8;

  localparam logic [PIX_W-1:0] VALUE_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] VALUE_BLACK = 8'd0;

  // Which neighbor directions lie inside the image
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_mask_t;

endpackage

[rtl/binary_neighbor_count_filter.sv]
// Binary 3x3 neighbor count filter over a raster pixel stream.
// Top level: line store memory, counters, window and output register.
// Depends on bncf_pkg.
`timescale 1ns / 1ps

// The block takes one request per clock (a pixel, or a flush after the
// image) and gives at most one filtered pixel per request. Each pixel is
// reduced to a white bit and kept in a MAX_WIDTH x 2-bit line store, a
// synchronous memory read in the accept cycle and written back when the
// request leaves the second stage; a same-column access by the next request
// (every request at image width 1, and the first request after an image)
// is forwarded from the write data. Results lag the pixel stream by one row
// plus one pixel, so after the last pixel send image_width + 1 flush
// requests to drain the image; the result for a request goes from the
// second stage registers into the output register and waits in the second
// stage while the output register still holds an unaccepted result. The
// sustained rate is one request per cycle, held back only by out_ready. The
// result with out_last set ends the image and restarts the stream. A flush
// sent while pixels of the image are still expected is dropped. Write width
// or height only while idle; either write restarts the stream.
module binary_neighbor_count_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bncf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bncf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [bncf_pkg::PIX_W-1:0]    in_pixel,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bncf_pkg::PIX_W-1:0]    out_value,
  output logic                          out_last
);

  import bncf_pkg::*;

  // Widths derived from the maximum image size
  localparam int CW  = $clog2(MAX_WIDTH);        // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // width value
  localparam int HW  = $clog2(MAX_HEIGHT + 1);   // height value
  localparam int ORW = $clog2(MAX_HEIGHT);       // output row
  localparam int RW  = $clog2(MAX_HEIGHT + 2);   // input row, runs past the image
  localparam int RSW = ((RW > 4) ? RW : 4) + 1;  // row compare width
  localparam int CSW = ((WW > 4) ? WW : 4) + 1;  // column compare width

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [WW-1:0] res;
    if (v == '0) begin
      res = WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(v);
    end
    return res;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [HW-1:0] res;
    if (v == '0) begin
      res = HW'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      res = HW'(MAX_HEIGHT);
    end else begin
      res = HW'(v);
    end
    return res;
  endfunction

  // Configuration registers
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [7:0]    thresh_r;
  logic [3:0]    min_nb_r;
  logic [3:0]    margin_r;

  // Stream counters
  logic [RW-1:0]  in_row_r,  in_row_nxt;
  logic [CW-1:0]  in_col_r,  in_col_nxt;
  logic [ORW-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;

  // Second stage
  logic           s1_vld_r;
  logic [CW-1:0]  s1_addr_r;
  logic           s1_bit_r;
  logic           s1_emit_r;
  logic           s1_last_r;
  nb_mask_t       s1_nb_r;
  logic           fwd_r;
  logic [1:0]     fwd_data_r;
  logic [1:0]     rd_r;
  logic [5:0]     win_r, win_nxt;

  // Output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_last_r;

  // Line store: bit 1 is the row above, bit 0 the current row
  logic [1:0] line_mem [MAX_WIDTH];

  logic cfg_fire, restart;
  logic in_fire, early_flush, load;
  logic s1_adv;

  // Stage 0 decode
  logic [RSW-1:0] row_x, height_x, margin_rx, orow_p1;
  logic [CSW-1:0] col_x, width_x, margin_cx, ocol_p1;
  logic           in_image, in_margin, pix_bit;
  logic           emit, last;
  nb_mask_t       nb;

  // Stage 1 datapath
  logic       top, mid;
  logic [1:0] src;
  logic [8:0] win9;
  logic [3:0] nb_count;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire && (cfg_index == CFG_IMAGE_WIDTH ||
                                  cfg_index == CFG_IMAGE_HEIGHT);

  // Stage 1 advances unless its result waits on a full output register
  assign s1_adv   = s1_vld_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Classify the request
  always_comb begin
    row_x     = RSW'(in_row_r);
    height_x  = RSW'(height_r);
    margin_rx = RSW'(margin_r);
    col_x     = CSW'(in_col_r);
    width_x   = CSW'(width_r);
    margin_cx = CSW'(margin_r);
    orow_p1   = RSW'(out_row_r) + RSW'(1);
    ocol_p1   = CSW'(out_col_r) + CSW'(1);

    in_image    = row_x < height_x;
    early_flush = in_image && (in_op == OP_FLUSH);
    load        = in_fire && !early_flush;

    in_margin = (row_x < margin_rx) || ((row_x + margin_rx) > height_x) ||
                (col_x < margin_cx) || ((col_x + margin_cx) > width_x);
    pix_bit   = in_image && !in_margin && (in_pixel >= thresh_r);

    emit = (row_x >= RSW'(2)) || (row_x == RSW'(1) && in_col_r != '0);
    last = (orow_p1 >= height_x) && (ocol_p1 >= width_x);

    nb.up    = out_row_r != '0;
    nb.down  = orow_p1 < height_x;
    nb.left  = out_col_r != '0;
    nb.right = ocol_p1 < width_x;
  end

  // Advance the counters
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (emit && last) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else begin
      if (emit) begin
        if (ocol_p1 >= width_x) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ORW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      if ((col_x + CSW'(1)) >= width_x) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
  end

  // Configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= clamp_w(RST_IMAGE_WIDTH);
      height_r  <= clamp_h(RST_IMAGE_HEIGHT);
      thresh_r  <= RST_THRESHOLD;
      min_nb_r  <= RST_MIN_NB;
      margin_r  <= RST_MARGIN;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:     width_r  <= clamp_w(cfg_data);
          CFG_IMAGE_HEIGHT:    height_r <= clamp_h(cfg_data);
          CFG_WHITE_THRESHOLD: thresh_r <= cfg_data[7:0];
          CFG_MIN_NEIGHBORS:   min_nb_r <= cfg_data[3:0];
          CFG_BORDER_MARGIN:   margin_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (restart) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
      end else if (load) begin
        in_row_r  <= in_row_nxt;
        in_col_r  <= in_col_nxt;
        out_row_r <= out_row_nxt;
        out_col_r <= out_col_nxt;
      end
    end
  end

  // Line store: read on accept, write back when stage 1 advances
  always_ff @(posedge clk) begin
    if (load) begin
      rd_r <= line_mem[in_col_r];
    end
    if (s1_adv) begin
      line_mem[s1_addr_r] <= {mid, s1_bit_r};
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (load) begin
        s1_vld_r <= 1'b1;
        // the entry is still being written by the request ahead
        fwd_r    <= s1_vld_r && (s1_addr_r == in_col_r);
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_addr_r <= in_col_r;
      s1_bit_r  <= pix_bit;
      s1_emit_r <= emit;
      s1_last_r <= emit && last;
      s1_nb_r   <= nb;
    end
    if (s1_adv) begin
      fwd_data_r <= {mid, s1_bit_r};
    end
  end

  // Shift the window and count white neighbors
  always_comb begin
    src  = fwd_r ? fwd_data_r : rd_r;
    top  = src[1];
    mid  = src[0];
    win9 = {win_r, top, mid, s1_bit_r};
    // left column 8..6, center 5..3, right 2..0; up, middle, down in each
    nb_count = 4'(win9[8] & s1_nb_r.left & s1_nb_r.up)
             + 4'(win9[7] & s1_nb_r.left)
             + 4'(win9[6] & s1_nb_r.left & s1_nb_r.down)
             + 4'(win9[5] & s1_nb_r.up)
             + 4'(win9[3] & s1_nb_r.down)
             + 4'(win9[2] & s1_nb_r.right & s1_nb_r.up)
             + 4'(win9[1] & s1_nb_r.right)
             + 4'(win9[0] & s1_nb_r.right & s1_nb_r.down);
    win_nxt = s1_last_r ? 6'd0 : win9[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (restart) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_value_r <= (nb_count >= min_nb_r) ? VALUE_WHITE : VALUE_BLACK;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

[verif/tb_binary_neighbor_count_filter.sv]
// Testbench for binary_neighbor_count_filter: directed and random raster images
// are streamed through the filter and every result is compared with a predictor.
// Depends on bncf_pkg and the binary_neighbor_count_filter RTL.
`timescale 1ns / 1ps

module tb_binary_neighbor_count_filter;
  import bncf_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 800;

  // no register sits behind this index
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_IDX = 3'd7;

  typedef enum int {PIX_UNIFORM, PIX_BRIGHT, PIX_NEAR} pix_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } filt_pixel_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_op     = OP_PIXEL;
  logic [PIX_W-1:0]      in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_value;
  logic                  out_last;

  // Predictor copy of the registers and the filter state
  logic [CFG_DATA_W-1:0] m_width;
  logic [CFG_DATA_W-1:0] m_height;
  logic [7:0]            m_thresh;
  logic [3:0]            m_min_nb;
  logic [3:0]            m_margin;
  bit                    prev_bits [MAX_W];
  bit                    curr_bits [MAX_W];
  logic [8:0]            win_bits;
  int unsigned           row_in, col_in, row_out, col_out;

  filt_pixel_t due_pixels [$];

  // Stimulus side view of the current setting
  int unsigned img_w   = 1;
  int unsigned img_h   = 1;
  logic [7:0]  cur_thr = RST_THRESHOLD;

  int          errors     = 0;
  int unsigned cycles     = 0;
  bit          idle_on    = 1'b1;
  int          ready_hold = 0;

  binary_neighbor_count_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void restart_image();
    win_bits = '0;
    row_in   = 0;
    col_in   = 0;
    row_out  = 0;
    col_out  = 0;
  endfunction

  function automatic void reset_filter_model();
    m_width  = RST_IMAGE_WIDTH;
    m_height = RST_IMAGE_HEIGHT;
    m_thresh = RST_THRESHOLD;
    m_min_nb = RST_MIN_NB;
    m_margin = RST_MARGIN;
    foreach (prev_bits[i]) begin
      prev_bits[i] = 1'b0;
      curr_bits[i] = 1'b0;
    end
    restart_image();
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        m_width = data;
        restart_image();
      end
      CFG_IMAGE_HEIGHT: begin
        m_height = data;
        restart_image();
      end
      CFG_WHITE_THRESHOLD: m_thresh = data[7:0];
      CFG_MIN_NEIGHBORS:   m_min_nb = data[3:0];
      CFG_BORDER_MARGIN:   m_margin = data[3:0];
      default: ;
    endcase
  endfunction

  // Advance the filter by one request; return 1 when it yields a pixel.
  function automatic bit filter_request(input logic op, input logic [PIX_W-1:0] px,
                                        output filt_pixel_t res);
    int unsigned w, h, c, count;
    int          r, cc, m, sh, k, j;
    bit          white, top, mid, in_image, margin;
    bit          up, down, left, right, col_ok, row_ok, emit;
    w        = clamp_dim(m_width, MAX_W);
    h        = clamp_dim(m_height, MAX_H);
    white    = 1'b0;
    emit     = 1'b0;
    count    = 0;
    res      = '0;
    in_image = row_in < h;
    if (col_in >= w) col_in = 0;
    // drop a flush that arrives while image pixels are still due
    if (in_image && op == OP_FLUSH) return 1'b0;
    // threshold the pixel, forcing the border band to black
    if (in_image) begin
      r      = int'(row_in);
      cc     = int'(col_in);
      m      = int'(m_margin);
      margin = r < m || r > int'(h) - m || cc < m || cc > int'(w) - m;
      white  = !margin && px >= m_thresh;
    end
    // rotate the two line stores and shift the window one column left
    c            = col_in % MAX_W;
    top          = prev_bits[c];
    mid          = curr_bits[c];
    prev_bits[c] = mid;
    curr_bits[c] = white;
    win_bits     = {win_bits[5:0], top, mid, white};
    if (row_in >= 2 || (row_in == 1 && col_in >= 1)) begin
      up    = row_out > 0;
      down  = row_out + 1 < h;
      left  = col_out > 0;
      right = col_out + 1 < w;
      // columns left, centre, right; rows up, centre, down
      for (k = 0; k < 3; k++) begin
        col_ok = (k == 0) ? left : (k == 2) ? right : 1'b1;
        sh     = 6 - 3 * k;
        for (j = 0; j < 3; j++) begin
          row_ok = (j == 0) ? up : (j == 2) ? down : 1'b1;
          if (col_ok && row_ok && !(k == 1 && j == 1)) count += win_bits[sh + 2 - j];
        end
      end
      res.value = (count >= m_min_nb) ? VALUE_WHITE : VALUE_BLACK;
      res.last  = (row_out + 1 >= h) && (col_out + 1 >= w);
      if (res.last) begin
        restart_image();
        return 1'b1;
      end
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
      emit = 1'b1;
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in = (row_in + 1) & 11'h7FF;
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, register tracking and request prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    filt_pixel_t want, res;
    if (rst_n) begin
      // compare before predicting: a request's pixel only leaves after its prediction
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual value %0d last %0b",
                   $time, out_value, out_last);
        end else begin
          want = due_pixels.pop_front();
          if (out_value !== want.value) begin
            errors++;
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, want.value, out_value);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (filter_request(in_op, in_pixel, res)) due_pixels.push_back(res);
      end
    end
  end

  // Randomly stall the result side after each pixel while idling is on
  always @(posedge clk) begin : drive_out_ready
    if (out_valid && out_ready) ready_hold = idle_on ? $urandom_range(0, 4) : 0;
    else if (ready_hold > 0) ready_hold--;
    out_ready <= rst_n && ready_hold == 0;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_binary_neighbor_count_filter NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [PIX_W-1:0] px);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every pending pixel is out, then let the block settle
  task automatic wait_idle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(negedge clk);
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    img_w = clamp_dim(w, MAX_W);
    img_h = clamp_dim(h, MAX_H);
  endtask

  // Narrow registers get random junk in the unused upper data bits
  task automatic set_filter(input logic [7:0] thr, input logic [3:0] min_nb,
                            input logic [3:0] margin);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_WHITE_THRESHOLD, {junk[10:8], thr});
    write_reg(CFG_MIN_NEIGHBORS, {junk[10:4], min_nb});
    write_reg(CFG_BORDER_MARGIN, {junk[6:0], margin});
    cur_thr = thr;
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(input pix_mode_t mode);
    int v;
    case (mode)
      PIX_BRIGHT: v = ($urandom_range(0, 3) != 0) ? $urandom_range(255, cur_thr)
                                                  : $urandom_range(0, 255);
      PIX_NEAR:   v = int'(cur_thr) + $urandom_range(0, 2) - 1;
      default:    v = $urandom_range(0, 255);
    endcase
    return v[PIX_W-1:0];
  endfunction

  // Optionally slip dropped flushes in among the pixels
  task automatic send_pixels(input int unsigned n, input pix_mode_t mode, input bit noisy);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_request(OP_FLUSH, PIX_W'($urandom));
      send_request(OP_PIXEL, draw_pixel(mode));
    end
  endtask

  // Drain the image; a surplus pixel acts as a flush
  task automatic send_drain(input bit noisy);
    for (int unsigned i = 0; i <= img_w; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_request(OP_PIXEL, PIX_W'($urandom));
      else send_request(OP_FLUSH, PIX_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_small();
    logic [PIX_W-1:0] vals [6];
    vals = '{8'd0, 8'd255, 8'd127, 8'd126, 8'd128, 8'd255};
    // filter registers keep their reset values: the margin blacks out everything
    set_dims(11'd3, 11'd2);
    foreach (vals[i]) begin
      if (i == 2) send_request(OP_FLUSH, 8'hFF);
      send_request(OP_PIXEL, vals[i]);
    end
    send_request(OP_FLUSH, 8'h00);
    send_request(OP_PIXEL, 8'hFF);
    send_request(OP_FLUSH, 8'h00);
    send_request(OP_FLUSH, 8'h00);
    wait_idle();
    // no margin, one white neighbor is enough; pixels around the threshold
    set_filter(RST_THRESHOLD, 4'd1, 4'd0);
    foreach (vals[i]) send_request(OP_PIXEL, vals[5 - i]);
    send_drain(1'b0);
    wait_idle();
  endtask

  task automatic test_filter_extremes();
    logic [3:0] mins [3];
    mins = '{4'd0, 4'd8, 4'd15};
    // all pixels white: zero passes all, eight passes the centre, above eight none
    set_dims(11'd3, 11'd3);
    foreach (mins[i]) begin
      set_filter(8'd0, mins[i], 4'd0);
      send_pixels(9, PIX_UNIFORM, 1'b0);
      send_drain(1'b0);
      wait_idle();
    end
    // top threshold with a one-pixel band, then a band wider than the image
    set_dims(11'd5, 11'd5);
    set_filter(8'd255, 4'd2, 4'd1);
    send_pixels(25, PIX_NEAR, 1'b0);
    send_drain(1'b0);
    wait_idle();
    set_filter(8'd128, 4'd3, 4'd15);
    send_pixels(25, PIX_BRIGHT, 1'b0);
    send_drain(1'b0);
    wait_idle();
    // zero sizes act as one
    set_dims(11'd0, 11'd0);
    set_filter(8'd0, 4'd0, 4'd0);
    send_pixels(1, PIX_UNIFORM, 1'b0);
    send_drain(1'b0);
    wait_idle();
    // back-to-back requests with no idling on either side
    idle_on = 1'b0;
    set_dims(11'd1, 11'd20);
    set_filter(8'd60, 4'd2, 4'd0);
    send_pixels(img_w * img_h, PIX_BRIGHT, 1'b0);
    send_drain(1'b0);
    wait_idle();
    set_dims(11'd16, 11'd4);
    set_filter(8'd100, 4'd1, 4'd2);
    send_pixels(img_w * img_h, PIX_UNIFORM, 1'b0);
    send_drain(1'b0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // A size write part way through an image restarts the stream
  task automatic test_restart_on_resize();
    set_dims(11'd5, 11'd4);
    set_filter(8'd90, 4'd2, 4'd0);
    send_pixels(8, PIX_BRIGHT, 1'b0);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    set_dims(11'd4, 11'd4);
    send_pixels(16, PIX_BRIGHT, 1'b0);
    send_drain(1'b0);
    send_pixels(6, PIX_BRIGHT, 1'b0);
    wait_idle();
    set_dims(11'd4, 11'd3);
    send_pixels(12, PIX_BRIGHT, 1'b0);
    send_drain(1'b0);
    wait_idle();
  endtask

  // Pause the sender mid-image until the block has caught up
  task automatic test_sender_pause();
    set_dims(11'd6, 11'd5);
    set_filter(8'd100, 4'd3, 4'd1);
    send_pixels(14, PIX_BRIGHT, 1'b1);
    wait_idle();
    send_pixels(16, PIX_BRIGHT, 1'b1);
    send_drain(1'b1);
    wait_idle();
  endtask

  task automatic test_random_images();
    int unsigned sent;
    pix_mode_t   mode;
    bit          noisy;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // reconfigure now and then; otherwise images follow back to back
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        wait_idle();
        set_dims(CFG_DATA_W'($urandom_range(0, 12)), CFG_DATA_W'($urandom_range(0, 8)));
        set_filter(8'($urandom),
                   4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 8)),
                   4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 3)));
      end
      idle_on = $urandom_range(0, 3) != 0;
      mode    = pix_mode_t'($urandom_range(0, 2));
      noisy   = $urandom_range(0, 3) == 0;
      // abandon an image part way and restart it with a size write
      if ($urandom_range(0, 11) == 0) begin
        send_pixels($urandom_range(0, img_w * img_h - 1), mode, noisy);
        wait_idle();
        set_dims(CFG_DATA_W'(img_w), CFG_DATA_W'(img_h));
      end
      send_pixels(img_w * img_h, mode, noisy);
      send_drain(noisy);
      sent += img_w * img_h + img_w + 1;
    end
    wait_idle();
  endtask

  initial begin
    reset_filter_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_small();
    test_filter_extremes();
    test_restart_on_resize();
    test_sender_pause();
    test_random_images();
    wait_idle();
    if (errors == 0) begin
      $display("tb_binary_neighbor_count_filter OK");
    end else begin
      $display("tb_binary_neighbor_count_filter NOT OK");
    end
    $finish;
  end

endmodule

[binary_neighbor_count_filter.f]
rtl/bncf_pkg.sv
rtl/binary_neighbor_count_filter.sv
verif/tb_binary_neighbor_count_filter.sv
